[hdl/rtte_pkg.sv]
// Shared constants, types and sequencer states of the RTT estimator.
`default_nettype none
package rtte_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int COUNT_BITS = 32;

  localparam int SAMPLE_W = 31;
  localparam int IN_W     = 32;
  localparam int FIX_W    = SAMPLE_W + FRAC_BITS;
  localparam int RTO_W    = FIX_W + 3;

  localparam int DIV_STEPS = FIX_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam int OUT_BITS = 3 * SAMPLE_W + 3 * FIX_W + RTO_W + COUNT_BITS;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DEV,
    ST_SMOOTH,
    ST_DIV,
    ST_RTO,
    ST_OUT
  } rtte_state_t;

  typedef struct packed {
    logic ready;
    logic prep;
    logic dev;
    logic smooth;
    logic mean_upd;
    logic rto;
    logic load_out;
  } rtte_ctrl_t;

endpackage
`default_nettype wire

[hdl/rtt_estimator_rto_unit.sv]
// Top level of the RTT estimator with retransmission timeout output.
`default_nettype none
// Each input transaction carries one signed round-trip-time sample in
// milliseconds; a negative sample counts as zero. For every sample the unit
// returns one output transaction with the latest, smallest and largest
// sample, a running mean, the smoothed RTT, the RTT variance and the
// retransmission timeout srtt + 4 * var, all fractional values in unsigned
// fixed point with 8 fraction bits, plus the saturating sample count. Once
// the count saturates the mean holds still while the other values keep
// tracking. The unit works on one sample at a time: an accepted sample
// passes through the prep, deviation, smoothing, divide, timeout and output
// states before its result is loaded into the output register, and the next
// sample is accepted only after that. The divide state waits for the 39-step
// serial divider that forms the running-mean increment; once the count has
// saturated the divider is skipped.
// The result waits in that register while the next sample is accepted, and
// a new result is held back only while the previous one has not been taken.
module rtt_estimator_rto_unit
  import rtte_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // sample_ms
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  // latest_rtt, min_rtt, max_rtt, mean_rtt, smoothed_rtt, rtt_variance,
  // retrans_timeout, samples_seen, then zero fill
  output logic [OUT_W-1:0]      m_tdata
);

  rtte_ctrl_t ctrl;
  logic       div_busy;
  logic       div_start;
  logic [FIX_W-1:0] div_quotient;
  logic [FIX_W-1:0] mean_diff;

  // Statistics state.
  logic                  have_sample;
  logic [SAMPLE_W-1:0]   last_sample;
  logic [SAMPLE_W-1:0]   lowest_sample;
  logic [SAMPLE_W-1:0]   highest_sample;
  logic [FIX_W-1:0]      running_mean;
  logic [COUNT_BITS-1:0] sample_count;
  logic [FIX_W-1:0]      srtt_value;
  logic [FIX_W-1:0]      variance_value;

  // Per-sample working registers.
  logic [SAMPLE_W-1:0]   ms;
  logic [FIX_W-1:0]      x;
  logic                  mean_neg;
  logic                  mean_en;
  logic [FIX_W-1:0]      dev;
  logic [RTO_W-1:0]      rto;

  logic [FIX_W+1:0]      var_sum;
  logic [FIX_W+2:0]      srtt_sum;

  assign s_tready = ctrl.ready;
  assign x        = {ms, {FRAC_BITS{1'b0}}};

  // The mean moves toward the new sample by the magnitude of the
  // difference divided by the new count, with the sign of the difference.
  assign mean_diff = (x >= running_mean) ? (x - running_mean) : (running_mean - x);
  assign div_start = ctrl.prep && (sample_count != COUNT_MAX);

  // Weighted sums for the smoothing step: 3 * var + dev and 7 * srtt + x.
  assign var_sum  = {1'b0, variance_value, 1'b0} + {2'b00, variance_value} + {2'b00, dev};
  assign srtt_sum = {srtt_value, 3'b000} - {3'b000, srtt_value} + {3'b000, x};

  rtte_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .div_busy (div_busy),
    .out_free (!m_tvalid || m_tready),
    .ctrl     (ctrl)
  );

  rtte_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mean_diff),
    .divisor  (sample_count + 1'b1),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Working registers for the sample in flight.
  always_ff @(posedge clk) begin
    if (ctrl.ready && s_tvalid) begin
      ms <= s_tdata[IN_W-1] ? '0 : s_tdata[SAMPLE_W-1:0];
    end
    if (ctrl.prep) begin
      mean_neg <= (x < running_mean);
      mean_en  <= (sample_count != COUNT_MAX);
    end
    if (ctrl.dev) begin
      dev <= (srtt_value >= x) ? (srtt_value - x) : (x - srtt_value);
    end
    if (ctrl.rto) begin
      rto <= {3'b000, srtt_value} + {1'b0, variance_value, 2'b00};
    end
  end

  // Statistics state; all of it clears on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      have_sample    <= 1'b0;
      last_sample    <= '0;
      lowest_sample  <= '0;
      highest_sample <= '0;
      running_mean   <= '0;
      sample_count   <= '0;
      srtt_value     <= '0;
      variance_value <= '0;
    end else begin
      if (ctrl.smooth) begin
        have_sample <= 1'b1;
        last_sample <= ms;
        if (!have_sample) begin
          // The first sample seeds the extremes, srtt and half-size variance.
          lowest_sample  <= ms;
          highest_sample <= ms;
          srtt_value     <= x;
          variance_value <= {1'b0, x[FIX_W-1:1]};
        end else begin
          if (ms < lowest_sample) begin
            lowest_sample <= ms;
          end
          if (ms > highest_sample) begin
            highest_sample <= ms;
          end
          variance_value <= var_sum[FIX_W+1:2];
          srtt_value     <= srtt_sum[FIX_W+2:3];
        end
      end
      if (ctrl.mean_upd && mean_en) begin
        running_mean <= mean_neg ? (running_mean - div_quotient)
                                 : (running_mean + div_quotient);
        sample_count <= sample_count + 1'b1;
      end
    end
  end

  // Output register; a new result replaces one that is being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      m_tdata <= {{(OUT_W - OUT_BITS){1'b0}}, sample_count, rto, variance_value,
                  srtt_value, running_mean, highest_sample, lowest_sample,
                  last_sample};
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("unit still ready right after accepting a sample");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |-> (!m_tvalid || m_tready))
    else $error("result loaded over one not yet taken");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    have_sample |-> (lowest_sample <= highest_sample))
    else $error("minimum sample above maximum sample");

  a_mean_not_saturated: assert property (@(posedge clk) disable iff (rst)
    ctrl.mean_upd && mean_en |-> (sample_count != COUNT_MAX))
    else $error("mean updated with saturated sample count");
`endif

endmodule
`default_nettype wire

[hdl/rtte_divider.sv]
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
module rtte_divider
  import rtte_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [FIX_W-1:0]      dividend,
  input  wire logic [COUNT_BITS-1:0] divisor,
  output logic                       busy,
  output logic [FIX_W-1:0]           quotient
);

  logic [DIV_CNT_W-1:0]  cnt;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] dvs;
  logic [COUNT_BITS:0]   rem_sh;
  logic [COUNT_BITS:0]   diff;

  // The quotient register starts out holding the dividend; its top bit
  // shifts into the partial remainder while a quotient bit enters below.
  assign rem_sh = {rem, quotient[FIX_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[FIX_W-2:0], ~diff[COUNT_BITS]};
      rem      <= diff[COUNT_BITS] ? rem_sh[COUNT_BITS-1:0] : diff[COUNT_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

[hdl/rtte_sequencer.sv]
// Sequencer that steps one sample through the update states.
`default_nettype none
module rtte_sequencer
  import rtte_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic div_busy,
  input  wire logic out_free,
  output rtte_ctrl_t ctrl
);

  rtte_state_t state;
  rtte_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_PREP;
      ST_PREP:   state_next = ST_DEV;
      ST_DEV:    state_next = ST_SMOOTH;
      ST_SMOOTH: state_next = ST_DIV;
      ST_DIV:    if (!div_busy) state_next = ST_RTO;
      ST_RTO:    state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state)
      ST_IDLE:   ctrl.ready    = 1'b1;
      ST_PREP:   ctrl.prep     = 1'b1;
      ST_DEV:    ctrl.dev      = 1'b1;
      ST_SMOOTH: ctrl.smooth   = 1'b1;
      ST_DIV:    ctrl.mean_upd = !div_busy;
      ST_RTO:    ctrl.rto      = 1'b1;
      ST_OUT:    ctrl.load_out = out_free;
      default:   ctrl          = '0;
    endcase
  end

endmodule
`default_nettype wire
